@@ rtl/mhpq_pkg.sv @@
package mhpq_pkg;

   // key/value pair as stored in the heap
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // slot numbers (1-based) and child slot numbers over the whole capacity range
   localparam int SLOT_W = 14;
   // tree level index
   localparam int LVL_W = 4;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] item_key;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] top_key;
      logic signed [31:0] top_value;
      logic [7:0]         entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_INSERT,
      MODE_FETCH,
      MODE_SIFT
   } mode_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_INSERT,
      STATE_PEEK,
      STATE_ROOT,
      STATE_LAST,
      STATE_SIFT
   } state_type;

   // token handed down the row of level cells
   // insert/fetch: slot is the 1-based target slot, target its level
   // sift: slot is the parent position inside the level above
   // insert: placed is set once the new pair has been written higher up the path
   typedef struct packed {
      logic                valid;
      mode_type            mode;
      logic                placed;
      logic [LVL_W-1:0]    target;
      logic [SLOT_W-1:0]   slot;
      logic [SLOT_W-1:0]   occ;
      entry_type           carry;
   } fwd_type;

   // write handed back to the level above during a sift
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] pos;
      entry_type         item;
   } bwd_type;

   typedef struct packed {
      logic      valid;
      entry_type item;
   } done_type;

   function automatic logic [LVL_W-1:0] slot_level(logic [SLOT_W-1:0] n);
      logic [LVL_W-1:0] lvl;
      lvl = '0;
      for (int i = 0; i < SLOT_W; i++) begin
         if (n[i]) begin
            lvl = LVL_W'(i);
         end
      end
      return lvl;
   endfunction

endpackage

@@ rtl/max_heap_priority_queue.sv @@
// Binary max-heap of signed key/value pairs: insert, extract maximum, peek maximum.
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with rsp_strobe, and the receiver cannot stall it.
// The heap is a chain of level cells, one per tree level, each owning the RAM of its
// level and reading, then comparing and writing, before handing on.
// No clearing pass after reset.
module max_heap_priority_queue import mhpq_pkg::*; #(
   parameter int CAPACITY = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // a sift must always find a level below the deepest parent it can reach
   localparam int LEVELS = $clog2(CAPACITY) + 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   entry_type top_ff, top_in;
   fwd_type launch_ff, launch_in;
   fwd_type sift_ff, sift_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_strobe_ff, rsp_strobe_in;

   fwd_type  cell_fwd_in  [LEVELS];
   fwd_type  cell_fwd_out [LEVELS];
   bwd_type  cell_bwd_in  [LEVELS];
   bwd_type  cell_bwd_out [LEVELS];
   done_type cell_done    [LEVELS];
   done_type done_any;

   logic [SLOT_W-1:0] ins_slot;
   logic [SLOT_W-1:0] last_slot;
   entry_type new_item;

   for (genvar d = 0; d < LEVELS; d++) begin : g_cell
      if (d == 0) begin : g_first
         assign cell_fwd_in[d] = launch_ff;
      end else if (d == 1) begin : g_second
         // a sift starts below the root
         assign cell_fwd_in[d] = cell_fwd_out[0].valid ? cell_fwd_out[0] : sift_ff;
      end else begin : g_rest
         assign cell_fwd_in[d] = cell_fwd_out[d-1];
      end
      if (d == LEVELS - 1) begin : g_tail
         assign cell_bwd_in[d] = '0;
      end else begin : g_link
         assign cell_bwd_in[d] = cell_bwd_out[d+1];
      end
      mhpq_cell #(
         .LEVEL(d)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .fwd_in  (cell_fwd_in[d]),
         .fwd_out (cell_fwd_out[d]),
         .bwd_in  (cell_bwd_in[d]),
         .bwd_out (cell_bwd_out[d]),
         .done_out(cell_done[d])
      );
   end

   always_comb begin
      done_any = '0;
      for (int d = 0; d < LEVELS; d++) begin
         if (cell_done[d].valid) begin
            done_any = cell_done[d];
         end
      end
   end

   assign ins_slot = SLOT_W'(occ_ff) + SLOT_W'(1);
   assign last_slot = SLOT_W'(occ_ff);
   assign new_item.key = req_data.item_key;
   assign new_item.value = req_data.item_value;

   always_comb begin
      state_in = state_ff;
      occ_in = occ_ff;
      top_in = top_ff;
      launch_in = '0;
      sift_in = '0;
      rsp_in = '0;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               case (req_data.operation)
                  OP_INSERT: begin
                     if (occ_ff >= CNT_W'(CAPACITY)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_FULL;
                        rsp_in.entry_count = 8'(occ_ff);
                     end else begin
                        occ_in = occ_ff + CNT_W'(1);
                        launch_in.valid = 1'b1;
                        launch_in.mode = MODE_INSERT;
                        launch_in.target = slot_level(ins_slot);
                        launch_in.slot = ins_slot;
                        launch_in.carry = new_item;
                        state_in = STATE_INSERT;
                     end
                  end
                  default: begin
                     if (occ_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                        rsp_in.entry_count = 8'(occ_ff);
                     end else begin
                        launch_in.valid = 1'b1;
                        launch_in.mode = MODE_FETCH;
                        launch_in.slot = SLOT_W'(1);
                        state_in = (req_data.operation == OP_EXTRACT) ? STATE_ROOT
                                                                      : STATE_PEEK;
                     end
                  end
               endcase
            end
         end
         STATE_INSERT: begin
            if (done_any.valid) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.entry_count = 8'(occ_ff);
               state_in = STATE_IDLE;
            end
         end
         STATE_PEEK: begin
            if (done_any.valid) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.top_key = done_any.item.key;
               rsp_in.top_value = done_any.item.value;
               rsp_in.entry_count = 8'(occ_ff);
               state_in = STATE_IDLE;
            end
         end
         STATE_ROOT: begin
            if (done_any.valid) begin
               top_in = done_any.item;
               launch_in.valid = 1'b1;
               launch_in.mode = MODE_FETCH;
               launch_in.target = slot_level(last_slot);
               launch_in.slot = last_slot;
               state_in = STATE_LAST;
            end
         end
         STATE_LAST: begin
            if (done_any.valid) begin
               occ_in = occ_ff - CNT_W'(1);
               if (occ_ff == CNT_W'(1)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = STATUS_OK;
                  rsp_in.top_key = top_ff.key;
                  rsp_in.top_value = top_ff.value;
                  rsp_in.entry_count = 8'(occ_in);
                  state_in = STATE_IDLE;
               end else begin
                  // last entry goes to the root and sinks from there
                  sift_in.valid = 1'b1;
                  sift_in.mode = MODE_SIFT;
                  sift_in.occ = SLOT_W'(occ_in);
                  sift_in.carry = done_any.item;
                  state_in = STATE_SIFT;
               end
            end
         end
         STATE_SIFT: begin
            if (done_any.valid) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.top_key = top_ff.key;
               rsp_in.top_value = top_ff.value;
               rsp_in.entry_count = 8'(occ_ff);
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         occ_ff <= '0;
         launch_ff.valid <= 1'b0;
         sift_ff.valid <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         launch_ff <= launch_in;
         sift_ff <= sift_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != STATE_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ rtl/mhpq_ram.sv @@
module mhpq_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/mhpq_cell.sv @@
module mhpq_cell import mhpq_pkg::*; #(
   parameter int LEVEL = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  fwd_type  fwd_in,
   output fwd_type  fwd_out,
   input  bwd_type  bwd_in,
   output bwd_type  bwd_out,
   output done_type done_out
);

   // level 0 holds the root alone; level d keeps its 2^d slots as sibling pairs
   localparam int ROWS = (LEVEL == 0) ? 1 : (1 << (LEVEL - 1));
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [SLOT_W-1:0] ROW_MASK = SLOT_W'(ROWS - 1);
   localparam logic [LVL_W-1:0] MY_LEVEL = LVL_W'(LEVEL);
   localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1) << LEVEL;

   fwd_type  tok_ff;
   fwd_type  fwd_out_ff, fwd_out_in;
   bwd_type  bwd_out_ff, bwd_out_in;
   done_type done_ff, done_in;
   logic [2*ENTRY_W-1:0] row_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [2*ENTRY_W-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [2*ENTRY_W-1:0] wr_data;

   logic [SLOT_W-1:0] in_idx;
   logic [SLOT_W-1:0] cur_shift;
   logic              cur_half;
   logic [AW-1:0]     cur_row;
   entry_type         lo, hi, cur, best;
   logic              at_target, take;
   logic [SLOT_W-1:0] left_slot;
   logic              lv, rv, pick_l, pick_r, moved;
   logic              bwd_half;

   // slot number shifted down to this level's part of the path
   function automatic logic [SLOT_W-1:0] path_idx(fwd_type t);
      logic [LVL_W-1:0] sh;
      sh = t.target - MY_LEVEL;
      return t.slot >> sh;
   endfunction

   mhpq_ram #(
      .WIDTH(2 * ENTRY_W),
      .DEPTH(ROWS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_en = fwd_in.valid;
   assign in_idx = (fwd_in.mode == MODE_SIFT) ? fwd_in.slot : (path_idx(fwd_in) >> 1);
   assign rd_addr = AW'(in_idx & ROW_MASK);

   assign cur_shift = path_idx(tok_ff);
   assign cur_half = (LEVEL != 0) && cur_shift[0];
   assign cur_row = AW'((cur_shift >> 1) & ROW_MASK);

   assign lo = entry_type'(rd_data[ENTRY_W-1:0]);
   assign hi = entry_type'(rd_data[2*ENTRY_W-1:ENTRY_W]);
   assign cur = cur_half ? hi : lo;
   assign at_target = (tok_ff.target == MY_LEVEL);
   // once the new pair is placed, the rest of the path shifts down one level
   assign take = at_target || tok_ff.placed ||
                 ($signed(tok_ff.carry.key) > $signed(cur.key));

   // children of the parent position sit in row slot of this level
   assign left_slot = FIRST_SLOT + {tok_ff.slot[SLOT_W-2:0], 1'b0};
   assign lv = (left_slot <= tok_ff.occ);
   assign rv = ((left_slot + SLOT_W'(1)) <= tok_ff.occ);
   assign pick_l = lv && ($signed(lo.key) > $signed(tok_ff.carry.key));
   assign best = pick_l ? lo : tok_ff.carry;
   assign pick_r = rv && ($signed(hi.key) > $signed(best.key));
   assign moved = pick_l || pick_r;

   assign bwd_half = (LEVEL != 0) && bwd_in.pos[0];

   always_comb begin
      wr_en = 1'b0;
      wr_addr = cur_row;
      wr_data = rd_data;
      fwd_out_in = '0;
      bwd_out_in = '0;
      done_in = '0;
      if (tok_ff.valid) begin
         case (tok_ff.mode)
            MODE_INSERT: begin
               if (take) begin
                  wr_en = 1'b1;
                  wr_data = cur_half ? {tok_ff.carry, lo} : {hi, tok_ff.carry};
               end
               if (at_target) begin
                  done_in.valid = 1'b1;
                  done_in.item = tok_ff.carry;
               end else begin
                  fwd_out_in = tok_ff;
                  fwd_out_in.placed = take;
                  fwd_out_in.carry = take ? cur : tok_ff.carry;
               end
            end
            MODE_FETCH: begin
               if (at_target) begin
                  done_in.valid = 1'b1;
                  done_in.item = cur;
               end else begin
                  fwd_out_in = tok_ff;
               end
            end
            MODE_SIFT: begin
               bwd_out_in.valid = 1'b1;
               bwd_out_in.pos = tok_ff.slot;
               bwd_out_in.item = pick_r ? hi : (pick_l ? lo : tok_ff.carry);
               if (moved) begin
                  fwd_out_in = tok_ff;
                  fwd_out_in.slot = {tok_ff.slot[SLOT_W-2:0], pick_r};
               end else begin
                  done_in.valid = 1'b1;
                  done_in.item = tok_ff.carry;
               end
            end
            default: begin
            end
         endcase
      end else if (bwd_in.valid) begin
         // parent write from the level below, merged into the row read last
         wr_en = 1'b1;
         wr_addr = AW'((bwd_in.pos >> 1) & ROW_MASK);
         wr_data = bwd_half ? {bwd_in.item, row_ff[ENTRY_W-1:0]}
                            : {row_ff[2*ENTRY_W-1:ENTRY_W], bwd_in.item};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         fwd_out_ff.valid <= 1'b0;
         bwd_out_ff.valid <= 1'b0;
         done_ff.valid <= 1'b0;
      end else begin
         tok_ff <= fwd_in;
         fwd_out_ff <= fwd_out_in;
         bwd_out_ff <= bwd_out_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_ff.valid) begin
         row_ff <= rd_data;
      end
   end

   assign fwd_out = fwd_out_ff;
   assign bwd_out = bwd_out_ff;
   assign done_out = done_ff;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import mhpq_pkg::*;

   localparam int CAPACITY = 128;
   localparam int RANDOM_ITEMS = 550;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_REPORTS = 40;
   // code 3 decodes as a peek
   localparam logic [1:0] OP_PEEK_ALIAS = 2'd3;

   typedef enum logic [1:0] {
      PHASE_GROW,
      PHASE_DRAIN,
      PHASE_CHURN
   } phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type   pending_q[$];
   rsp_type   expected_q[$];
   entry_type heap_mirror[1:CAPACITY];
   int        heap_size = 0;
   int        plan_count = 0;
   int        total_requests = 0;
   int        accepted_count = 0;
   int        error_count = 0;
   int        full_seen = 0;
   int        empty_seen = 0;
   int        fetch_seen = 0;

   max_heap_priority_queue #(.CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void swap_entries(int a, int b);
      entry_type tmp;
      tmp = heap_mirror[a];
      heap_mirror[a] = heap_mirror[b];
      heap_mirror[b] = tmp;
   endfunction

   // applies one request to the mirror heap and returns the result it must give
   function automatic rsp_type heap_apply(req_type r);
      rsp_type res;
      int      pos;
      int      best;
      int      kid;
      bit      settled;
      res = '0;
      res.status = STATUS_OK;
      if (r.operation == OP_INSERT) begin
         if (heap_size >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            heap_size++;
            heap_mirror[heap_size].key = r.item_key;
            heap_mirror[heap_size].value = r.item_value;
            pos = heap_size;
            while (pos > 1 &&
                   $signed(heap_mirror[pos].key) > $signed(heap_mirror[pos / 2].key)) begin
               swap_entries(pos, pos / 2);
               pos = pos / 2;
            end
         end
      end else if (heap_size == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.top_key = heap_mirror[1].key;
         res.top_value = heap_mirror[1].value;
         if (r.operation == OP_EXTRACT) begin
            heap_mirror[1] = heap_mirror[heap_size];
            heap_size--;
            pos = 1;
            settled = 1'b0;
            // larger child wins, left child on a tie
            while (!settled) begin
               best = pos;
               kid = 2 * pos;
               if (kid <= heap_size &&
                   $signed(heap_mirror[kid].key) > $signed(heap_mirror[best].key)) begin
                  best = kid;
               end
               if (kid + 1 <= heap_size &&
                   $signed(heap_mirror[kid + 1].key) > $signed(heap_mirror[best].key)) begin
                  best = kid + 1;
               end
               if (best == pos) begin
                  settled = 1'b1;
               end else begin
                  swap_entries(pos, best);
                  pos = best;
               end
            end
         end
      end
      res.entry_count = 8'(heap_size);
      return res;
   endfunction

   task automatic queue_request(logic [1:0] op, logic [31:0] key, logic [31:0] value);
      req_type r;
      r.operation = op;
      r.item_key = key;
      r.item_value = value;
      pending_q.push_back(r);
      if (op == OP_INSERT && plan_count < CAPACITY) begin
         plan_count++;
      end else if (op == OP_EXTRACT && plan_count > 0) begin
         plan_count--;
      end
   endtask

   // half the keys from a narrow band so equal keys are common
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 9))
         0: begin
            return 32'h7fff_ffff;
         end
         1: begin
            return 32'h8000_0000;
         end
         2, 3, 4: begin
            return $urandom;
         end
         default: begin
            return 32'($urandom_range(0, 15)) - 32'd8;
         end
      endcase
   endfunction

   function automatic logic [1:0] pick_op(phase_type phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW: begin
            if (roll < 88) return OP_INSERT;
            else if (roll < 92) return OP_PEEK;
            else if (roll < 94) return OP_PEEK_ALIAS;
            else return OP_EXTRACT;
         end
         PHASE_DRAIN: begin
            if (roll < 82) return OP_EXTRACT;
            else if (roll < 90) return OP_PEEK;
            else if (roll < 95) return OP_PEEK_ALIAS;
            else return OP_INSERT;
         end
         default: begin
            if (roll < 45) return OP_INSERT;
            else if (roll < 80) return OP_EXTRACT;
            else if (roll < 92) return OP_PEEK;
            else return OP_PEEK_ALIAS;
         end
      endcase
   endfunction

   task automatic build_stimulus();
      phase_type phase;
      int        edge_hits;
      int        churn_left;
      // empty heap on every fetch flavor
      queue_request(OP_PEEK, 32'h1234_5678, 32'h9abc_def0);
      queue_request(OP_EXTRACT, 32'hffff_ffff, 32'hffff_ffff);
      queue_request(OP_PEEK_ALIAS, 32'h0, 32'h0);
      // extreme keys and values, then equal keys
      queue_request(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      queue_request(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      queue_request(OP_INSERT, 32'h0, 32'h0);
      queue_request(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      queue_request(OP_INSERT, 32'd5, 32'd1);
      queue_request(OP_INSERT, 32'd5, 32'd2);
      queue_request(OP_INSERT, 32'd5, 32'd3);
      queue_request(OP_PEEK, 32'hffff_ffff, 32'hffff_ffff);
      queue_request(OP_PEEK_ALIAS, 32'h5555_5555, 32'haaaa_aaaa);
      for (int i = 0; i < 8; i++) begin
         queue_request(OP_EXTRACT, $urandom, $urandom);
      end
      queue_request(OP_PEEK, 32'h0, 32'h0);

      phase = PHASE_GROW;
      edge_hits = 0;
      churn_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         queue_request(pick_op(phase), pick_key(), $urandom);
         case (phase)
            PHASE_GROW: begin
               if (plan_count == CAPACITY) edge_hits++;
               if (edge_hits >= 4) begin
                  phase = PHASE_DRAIN;
                  edge_hits = 0;
               end
            end
            PHASE_DRAIN: begin
               if (plan_count == 0) edge_hits++;
               if (edge_hits >= 3) begin
                  phase = PHASE_CHURN;
                  edge_hits = 0;
                  churn_left = $urandom_range(30, 80);
               end
            end
            default: begin
               churn_left--;
               if (churn_left <= 0) phase = PHASE_GROW;
            end
         endcase
      end
      total_requests = pending_q.size();
   endtask

   // request driver: holds an offered request until taken, random gaps otherwise
   always @(posedge clock) begin
      logic gap;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_q.push_back(heap_apply(req_data));
            accepted_count++;
         end
         if (!(start && busy)) begin
            gap = ($urandom_range(0, 99) < 10) &&
                  !(accepted_count >= 200 && accepted_count < 330);
            if (pending_q.size() > 0 && !gap) begin
               req_data <= pending_q.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: result with none expected, expected nothing, got %p",
                        $time, rsp_data);
            end
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.status !== want.status) begin
               report_field("status", 32'(want.status), 32'(rsp_data.status));
            end
            if (rsp_data.top_key !== want.top_key) begin
               report_field("top_key", want.top_key, rsp_data.top_key);
            end
            if (rsp_data.top_value !== want.top_value) begin
               report_field("top_value", want.top_value, rsp_data.top_value);
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               report_field("entry_count", 32'(want.entry_count), 32'(rsp_data.entry_count));
            end
            if (want.status == STATUS_FULL) full_seen++;
            if (want.status == STATUS_EMPTY) empty_seen++;
            if (want.status == STATUS_OK && rsp_data.entry_count != 0 ||
                want.top_key != 0 || want.top_value != 0) begin
               fetch_seen++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_requests || expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d requests checked, %0d refused on a full heap, %0d on an empty heap",
               accepted_count, full_seen, empty_seen);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: %0d mismatches", error_count);
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ max_heap_priority_queue.f @@
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_cell.sv
rtl/max_heap_priority_queue.sv
sim/tb.sv
